FILE: hdl/tcli_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcli_pkg
// Shared types, widths and codes for the tone curve LUT interpolation unit.
// ----------------------------------------------------------------------------
package tcli_pkg;

   // Sample and curve geometry
   localparam int PIX_W         = 14;
   localparam int FRAC_W        = 7;
   localparam int SEG_W         = PIX_W - FRAC_W;
   localparam int KNOT_BITS_DEF = 10;
   localparam int TVAL_W        = 10;
   localparam int TIDX_W        = 8;
   localparam int TABLE_DEPTH   = 129;
   localparam int EVEN_DEPTH    = (TABLE_DEPTH + 1) / 2;
   localparam int ODD_DEPTH     = TABLE_DEPTH / 2;
   localparam int EVEN_AW       = $clog2(EVEN_DEPTH);
   localparam int ODD_AW        = $clog2(ODD_DEPTH);

   // Datapath widths
   localparam int DY_W    = 15;
   localparam int PROD_W  = DY_W + FRAC_W + 1;
   localparam int SUM_L_W = 31;
   localparam int T_W     = 17;
   localparam int S_W     = 18;
   localparam int V_W     = 16;
   localparam int SEED_W  = 5;

   // Interpolation constants
   localparam int SCALE_SH   = 7;     // x129 = x128 + x1
   localparam int LAST_LSB   = 12;
   localparam int MID_LSB    = 5;
   localparam int ROUND_LAST = 2048;
   localparam int ROUND_MID  = 16;
   localparam int ROUND_OUT  = 2;

   localparam logic [SEG_W-1:0]  LAST_SEGMENT = 7'd127;
   localparam logic [3:0]        KNOT_FILL    = 4'hF;
   localparam logic [PIX_W-1:0]  PIX_MAX      = 14'h3fff;
   localparam logic [SEED_W-1:0] SEED_RESET   = 5'd8;

   // Frame geometry
   localparam int                DIM_W        = 13;
   localparam logic [DIM_W-1:0]  WIDTH_RESET  = 13'd1920;
   localparam logic [DIM_W-1:0]  HEIGHT_RESET = 13'd1080;

   // Register port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;
   localparam int REG_W  = 2;
   localparam logic [REG_W-1:0] REG_TONE_ENABLE   = 2'd0;
   localparam logic [REG_W-1:0] REG_DITHER_ENABLE = 2'd1;
   localparam logic [REG_W-1:0] REG_FRAME_WIDTH   = 2'd2;
   localparam logic [REG_W-1:0] REG_FRAME_HEIGHT  = 2'd3;

   // Request operations
   localparam logic OP_PIXEL       = 1'b0;
   localparam logic OP_TABLE_WRITE = 1'b1;

   // Pipeline control handed to each channel slice
   typedef struct packed {
      logic s1_load;
      logic s2_load;
      logic s3_load;
      logic out_load;
      logic tone_en;
      logic dither_en;
      logic parity;     // row parity of the item in stage 3
      logic frame_end;  // item in stage 3 closes a frame
   } tcli_ctl_type;

endpackage

FILE: hdl/tcli_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcli_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/tcli_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcli_chan
// One color channel: knot decode, interpolation, dither seeds and clip.
// ----------------------------------------------------------------------------
module tcli_chan import tcli_pkg::*; #(
   parameter int KNOT_BITS = KNOT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tcli_ctl_type         ctl,
   input  logic [PIX_W-1:0]     req_pixel,
   input  logic [KNOT_BITS-1:0] even_knot,
   input  logic [KNOT_BITS-1:0] odd_knot,
   output logic [PIX_W-1:0]     result
);

   // stage 1: knots arrive from the RAMs
   logic [PIX_W-1:0]         s1_pix_ff, s1_pix_in;
   logic [SEG_W-1:0]         idx1;
   logic [FRAC_W-1:0]        frac1;
   logic [KNOT_BITS-1:0]     knot_lo, knot_hi;
   logic [PIX_W-1:0]         lo1, hi1;
   logic signed [DY_W-1:0]   dy1;
   logic signed [PROD_W-1:0] prod1;

   // stage 2: slope term
   logic [PIX_W-1:0]         s2_pix_ff, s2_pix_in;
   logic [PIX_W-1:0]         s2_lo_ff, s2_lo_in;
   logic [PROD_W-1:0]        s2_prod_ff, s2_prod_in;
   logic                     s2_last_ff, s2_last_in;
   logic [SUM_L_W-1:0]       ext_l, sum_l;
   logic [PROD_W:0]          sum_n;
   logic [T_W-1:0]           t2;

   // stage 3: seed add, clip
   logic [PIX_W-1:0]         s3_pix_ff, s3_pix_in;
   logic [PIX_W-1:0]         s3_lo_ff, s3_lo_in;
   logic [T_W-1:0]           s3_t_ff, s3_t_in;
   logic [SEED_W-1:0]        seed_ff [2];
   logic [SEED_W-1:0]        seed_in [2];
   logic [SEED_W-1:0]        seed_cur;
   logic [S_W-1:0]           t_ext, s_sum, rnd;
   logic [V_W-1:0]           v_d, v_n, v_sel;
   logic [PIX_W-1:0]         clipped;

   always_comb begin
      idx1    = s1_pix_ff[PIX_W-1:FRAC_W];
      frac1   = s1_pix_ff[FRAC_W-1:0];
      // odd segment: lower knot sits in the odd bank
      knot_lo = idx1[0] ? odd_knot  : even_knot;
      knot_hi = idx1[0] ? even_knot : odd_knot;
      lo1     = (knot_lo != '0) ? PIX_W'({knot_lo, KNOT_FILL}) : '0;
      hi1     = (knot_hi != '0) ? PIX_W'({knot_hi, KNOT_FILL}) : PIX_W'(1);
      dy1     = {1'b0, hi1} - {1'b0, lo1};
      prod1   = dy1 * $signed({1'b0, frac1});
   end

   always_comb begin
      ext_l = {{(SUM_L_W-PROD_W){s2_prod_ff[PROD_W-1]}}, s2_prod_ff};
      sum_l = (ext_l << SCALE_SH) + ext_l + SUM_L_W'(ROUND_LAST);
      sum_n = {s2_prod_ff[PROD_W-1], s2_prod_ff} + (PROD_W+1)'(ROUND_MID);
      t2    = s2_last_ff ? sum_l[LAST_LSB+T_W-1:LAST_LSB]
                         : sum_n[MID_LSB+T_W-1:MID_LSB];
   end

   always_comb begin
      seed_cur = seed_ff[ctl.parity];
      t_ext    = {s3_t_ff[T_W-1], s3_t_ff};
      s_sum    = S_W'({s3_lo_ff, 2'b00}) + t_ext + S_W'(seed_cur);
      rnd      = t_ext + S_W'(ROUND_OUT);
      v_d      = s_sum[S_W-1:2];
      v_n      = V_W'(s3_lo_ff) + rnd[S_W-1:2];
      v_sel    = ctl.dither_en ? v_d : v_n;
      if (v_sel[V_W-1]) begin
         clipped = '0;
      end else if (v_sel[PIX_W]) begin
         clipped = PIX_MAX;
      end else begin
         clipped = v_sel[PIX_W-1:0];
      end
      result = ctl.tone_en ? clipped : s3_pix_ff;
   end

   // seed update happens as the item leaves stage 3; frame end wins
   always_comb begin
      seed_in = seed_ff;
      if (ctl.out_load) begin
         if (ctl.tone_en && ctl.dither_en) begin
            seed_in[ctl.parity] = s_sum[SEED_W-1:0];
         end
         if (ctl.frame_end) begin
            seed_in[0] = SEED_RESET;
            seed_in[1] = SEED_RESET;
         end
      end
   end

   always_comb begin
      s1_pix_in  = ctl.s1_load ? req_pixel : s1_pix_ff;
      s2_pix_in  = ctl.s2_load ? s1_pix_ff : s2_pix_ff;
      s2_lo_in   = ctl.s2_load ? lo1 : s2_lo_ff;
      s2_prod_in = ctl.s2_load ? prod1 : s2_prod_ff;
      s2_last_in = ctl.s2_load ? (idx1 == LAST_SEGMENT) : s2_last_ff;
      s3_pix_in  = ctl.s3_load ? s2_pix_ff : s3_pix_ff;
      s3_lo_in   = ctl.s3_load ? s2_lo_ff : s3_lo_ff;
      s3_t_in    = ctl.s3_load ? t2 : s3_t_ff;
   end

   always_ff @(posedge clock) begin
      s1_pix_ff  <= s1_pix_in;
      s2_pix_ff  <= s2_pix_in;
      s2_lo_ff   <= s2_lo_in;
      s2_prod_ff <= s2_prod_in;
      s2_last_ff <= s2_last_in;
      s3_pix_ff  <= s3_pix_in;
      s3_lo_ff   <= s3_lo_in;
      s3_t_ff    <= s3_t_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff[0] <= SEED_RESET;
         seed_ff[1] <= SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

endmodule

FILE: hdl/tone_curve_lut_interp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_curve_lut_interp_unit
// Global tone mapping of three 14-bit channels through a 129-knot curve.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): valid/ready. A request is either a pixel
//    (req_operation = OP_PIXEL) or a curve knot write (OP_TABLE_WRITE).
//    Knot writes give no response; pixels give exactly one.
//  - Response channel (rsp_*): valid/ready, three mapped channels.
//  - Register port (csr_*): APB-style, pready tied high, registers at
//    byte offsets 0 tone enable, 4 dither enable, 8 width, 12 height.
//    Write registers only with no pixel in flight.
//  - Path: an accepted pixel moves through the RAM read, the slope
//    multiply, the slope scale, and the seed add and clip into the
//    response register before it shows on rsp_valid.
//  - Throughput: one request per clock when not stalled. Each channel
//    reads its two knots at once from even/odd knot RAMs, one read port each.
//  - Stalls: every stage has its own valid and moves when the next stage
//    is free, so bubbles close up and up to four pixels are held while
//    rsp_ready is low; req_ready drops only when all stages are full.
//  - Reset: registers return to their defaults, position counters to 0,
//    dither seeds to 8. Knot RAM contents are not cleared; load every
//    knot a pixel can touch before enabling the curve.
// ----------------------------------------------------------------------------
module tone_curve_lut_interp_unit import tcli_pkg::*; #(
   parameter int KNOT_BITS = KNOT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_operation,
   input  logic [PIX_W-1:0]  req_pixel_c0,
   input  logic [PIX_W-1:0]  req_pixel_c1,
   input  logic [PIX_W-1:0]  req_pixel_c2,
   input  logic [TIDX_W-1:0] req_table_index,
   input  logic [TVAL_W-1:0] req_table_value,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [PIX_W-1:0]  rsp_out_c0,
   output logic [PIX_W-1:0]  rsp_out_c1,
   output logic [PIX_W-1:0]  rsp_out_c2,
   // register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   // ---------------- configuration registers ----------------
   logic             tone_en_ff, tone_en_in;
   logic             dither_en_ff, dither_en_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             csr_wr;
   logic [REG_W-1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      tone_en_in   = tone_en_ff;
      dither_en_in = dither_en_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_TONE_ENABLE:   tone_en_in   = csr_pwdata[0];
            REG_DITHER_ENABLE: dither_en_in = csr_pwdata[0];
            REG_FRAME_WIDTH:   width_in     = csr_pwdata[DIM_W-1:0];
            REG_FRAME_HEIGHT:  height_in    = csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_TONE_ENABLE:   csr_prdata = CSR_DW'(tone_en_ff);
         REG_DITHER_ENABLE: csr_prdata = CSR_DW'(dither_en_ff);
         REG_FRAME_WIDTH:   csr_prdata = CSR_DW'(width_ff);
         REG_FRAME_HEIGHT:  csr_prdata = CSR_DW'(height_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline handshake ----------------
   // s1: knot RAM output, s2: slope product, s3: slope term, then response
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rdy_out, rdy3, rdy2;
   logic load2, load3, load_out;
   logic req_take, pix_take, tbl_take;

   assign rdy_out   = !rsp_valid_ff || rsp_ready;
   assign load_out  = v3_ff && rdy_out;
   assign rdy3      = !v3_ff || rdy_out;
   assign load3     = v2_ff && rdy3;
   assign rdy2      = !v2_ff || rdy3;
   assign load2     = v1_ff && rdy2;
   assign req_ready = !v1_ff || rdy2;
   assign req_take  = req_valid && req_ready;
   assign pix_take  = req_take && (req_operation == OP_PIXEL);
   assign tbl_take  = req_take && (req_operation == OP_TABLE_WRITE);

   always_comb begin
      v1_in        = req_ready ? pix_take : v1_ff;
      v2_in        = rdy2 ? v1_ff : v2_ff;
      v3_in        = rdy3 ? v2_ff : v3_ff;
      rsp_valid_in = rdy_out ? v3_ff : rsp_valid_ff;
   end

   // ---------------- frame position ----------------
   logic [DIM_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [DIM_W-1:0] col_inc, row_inc;
   logic             row_wrap, frame_wrap;
   logic             par1_ff, par1_in, par2_ff, par2_in, par3_ff, par3_in;
   logic             fe1_ff, fe1_in, fe2_ff, fe2_in, fe3_ff, fe3_in;

   always_comb begin
      col_inc    = col_ff + DIM_W'(1);
      row_inc    = row_ff + DIM_W'(1);
      row_wrap   = (col_inc >= width_ff);
      frame_wrap = row_wrap && (row_inc >= height_ff);
      col_in     = col_ff;
      row_in     = row_ff;
      if (pix_take) begin
         col_in = row_wrap ? '0 : col_inc;
         if (row_wrap) begin
            row_in = frame_wrap ? '0 : row_inc;
         end
      end
   end

   // parity and frame end ride along with the pixel
   always_comb begin
      par1_in = pix_take ? row_ff[0] : par1_ff;
      fe1_in  = pix_take ? frame_wrap : fe1_ff;
      par2_in = load2 ? par1_ff : par2_ff;
      fe2_in  = load2 ? fe1_ff : fe2_ff;
      par3_in = load3 ? par2_ff : par3_ff;
      fe3_in  = load3 ? fe2_ff : fe3_ff;
   end

   // ---------------- channel slices and knot RAMs ----------------
   tcli_ctl_type     ctl;
   logic [PIX_W-1:0] pix_req [3];
   logic [PIX_W-1:0] chan_res [3];
   logic [PIX_W-1:0] out_ff [3];
   logic [PIX_W-1:0] out_in [3];
   logic             wr_even, wr_odd;

   assign ctl.s1_load   = pix_take;
   assign ctl.s2_load   = load2;
   assign ctl.s3_load   = load3;
   assign ctl.out_load  = load_out;
   assign ctl.tone_en   = tone_en_ff;
   assign ctl.dither_en = dither_en_ff;
   assign ctl.parity    = par3_ff;
   assign ctl.frame_end = fe3_ff;

   assign pix_req[0] = req_pixel_c0;
   assign pix_req[1] = req_pixel_c1;
   assign pix_req[2] = req_pixel_c2;

   // knot k lives in the even bank at k/2 when k is even, else the odd bank
   assign wr_even = tbl_take && (req_table_index < TIDX_W'(TABLE_DEPTH))
                    && !req_table_index[0];
   assign wr_odd  = tbl_take && (req_table_index < TIDX_W'(TABLE_DEPTH))
                    && req_table_index[0];

   for (genvar c = 0; c < 3; c++) begin : g_chan
      logic [SEG_W-1:0]     seg;
      logic [EVEN_AW-1:0]   even_rd;
      logic [ODD_AW-1:0]    odd_rd;
      logic [KNOT_BITS-1:0] even_knot, odd_knot;

      // segment s needs knots s and s+1: one from each bank
      assign seg     = pix_req[c][PIX_W-1:FRAC_W];
      assign even_rd = EVEN_AW'(seg[SEG_W-1:1]) + EVEN_AW'(seg[0]);
      assign odd_rd  = seg[SEG_W-1:1];

      tcli_ram #(
         .WIDTH (KNOT_BITS),
         .DEPTH (EVEN_DEPTH)
      ) u_even_ram (
         .clock   (clock),
         .wr_en   (wr_even),
         .wr_addr (req_table_index[EVEN_AW:1]),
         .wr_data (req_table_value[KNOT_BITS-1:0]),
         .rd_en   (pix_take),
         .rd_addr (even_rd),
         .rd_data (even_knot)
      );

      tcli_ram #(
         .WIDTH (KNOT_BITS),
         .DEPTH (ODD_DEPTH)
      ) u_odd_ram (
         .clock   (clock),
         .wr_en   (wr_odd),
         .wr_addr (req_table_index[ODD_AW:1]),
         .wr_data (req_table_value[KNOT_BITS-1:0]),
         .rd_en   (pix_take),
         .rd_addr (odd_rd),
         .rd_data (odd_knot)
      );

      tcli_chan #(
         .KNOT_BITS (KNOT_BITS)
      ) u_chan (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .req_pixel (pix_req[c]),
         .even_knot (even_knot),
         .odd_knot  (odd_knot),
         .result    (chan_res[c])
      );

      assign out_in[c] = load_out ? chan_res[c] : out_ff[c];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_c0 = out_ff[0];
   assign rsp_out_c1 = out_ff[1];
   assign rsp_out_c2 = out_ff[2];

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         tone_en_ff   <= 1'b0;
         dither_en_ff <= 1'b0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         tone_en_ff   <= tone_en_in;
         dither_en_ff <= dither_en_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      par1_ff <= par1_in;
      par2_ff <= par2_in;
      par3_ff <= par3_in;
      fe1_ff  <= fe1_in;
      fe2_ff  <= fe2_in;
      fe3_ff  <= fe3_in;
      out_ff  <= out_in;
   end

endmodule

FILE: hdl/tcli_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcli_check
// Port-level checks for the tone curve unit, bound to the top level.
// ----------------------------------------------------------------------------
module tcli_check import tcli_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_operation,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [PIX_W-1:0] rsp_out_c0,
   input logic [PIX_W-1:0] rsp_out_c1,
   input logic [PIX_W-1:0] rsp_out_c2
);

   // pixels accepted but not yet answered
   logic [2:0] cnt_ff, cnt_in;
   logic       inc, dec;

   assign inc    = req_valid && req_ready && (req_operation == OP_PIXEL);
   assign dec    = rsp_valid && rsp_ready;
   assign cnt_in = cnt_ff + 3'(inc) - 3'(dec);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (cnt_ff != 3'd0))
      else $error("response with no pixel in flight");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("more pixels in flight than pipeline stages");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 3'd0) |-> req_ready)
      else $error("request stalled with empty pipeline");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_c0)
         && $stable(rsp_out_c1) && $stable(rsp_out_c2))
      else $error("stalled response changed");

endmodule

bind tone_curve_lut_interp_unit tcli_check u_tcli_check (.*);
